### hw/rtl/lbm_pkg.sv
package lbm_pkg;

  localparam int DW      = 32;
  localparam int FB      = 28;
  localparam int NB      = DW + FB;
  localparam int QB      = DW - 1;
  localparam int NDIR    = 9;
  localparam int DIV_LAT = QB + 2;
  localparam int QN      = 10;

  typedef logic signed [DW-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_FLUID,
    KIND_SOLID,
    KIND_INLET,
    KIND_OUTLET
  } kind_t;

  localparam logic REG_RELAX  = 1'b0;
  localparam logic REG_OUTDEN = 1'b1;

  localparam word_t WMAX   = {1'b0, {(DW-1){1'b1}}};
  localparam word_t WMIN   = {1'b1, {(DW-1){1'b0}}};
  localparam word_t ONE    = word_t'(64'd1 << FB);
  localparam word_t W_REST = word_t'(((64'd8 << FB) + 64'd9) / 64'd18);
  localparam word_t W_AXIS = word_t'(((64'd2 << FB) + 64'd9) / 64'd18);
  localparam word_t W_DIAG = word_t'(((64'd2 << FB) + 64'd36) / 64'd72);

  localparam logic [DW-1:0] DIV3_MAGIC = 32'hAAAAAAAB;
  localparam int DIV3_SHIFT = 33;
  localparam int DIV6_SHIFT = 34;

  localparam int REVERSE [0:NDIR-1] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
  localparam int DIR_X   [0:NDIR-1] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y   [0:NDIR-1] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int W_SEL   [0:NDIR-1] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

  typedef struct packed {
    logic neg;
    logic pos;
    logic bad;
    logic ovf;
  } div_flag_t;

  typedef struct packed {
    word_t [NDIR-1:0] f;
    kind_t            kind;
    logic [FB-1:0]    speed;
  } in_t;

  typedef struct packed {
    word_t r5;
    word_t mxp;
    word_t mxn;
    word_t myp;
    word_t myn;
    word_t s;
    word_t h;
  } aux_t;

  typedef struct packed {
    word_t [NDIR-1:0] f;
    kind_t            kind;
    logic [FB-1:0]    speed;
    word_t            h;
    word_t            rho;
  } ctx_t;

  typedef struct packed {
    word_t [NDIR-1:0] f;
    kind_t            kind;
    word_t            h;
    word_t            rho;
    word_t            u;
    word_t            vy;
    word_t            ru;
    word_t            uu;
    word_t            vv;
    word_t            qs;
    word_t            r6;
    word_t            tq;
    word_t            usq;
    word_t [2:0]      rw;
    logic             ru_neg;
    logic             ru2_neg;
    logic [63:0]      p3;
    logic [63:0]      p6;
    word_t [NDIR-1:0] t;
    word_t [NDIR-1:0] tt;
    word_t [NDIR-1:0] poly;
    word_t [NDIR-1:0] feq;
    word_t [NDIR-1:0] diff;
    word_t [NDIR-1:0] prod;
  } post_t;

  function automatic word_t sat_w(input logic signed [DW:0] x);
    if (x[DW] != x[DW-1]) begin
      return x[DW] ? WMIN : WMAX;
    end
    return word_t'(x[DW-1:0]);
  endfunction

  function automatic word_t addq(input word_t a, input word_t b);
    logic signed [DW:0] s;
    s = a + b;
    return sat_w(s);
  endfunction

  function automatic word_t subq(input word_t a, input word_t b);
    logic signed [DW:0] s;
    s = a - b;
    return sat_w(s);
  endfunction

  function automatic word_t mulq(input word_t a, input word_t b);
    logic signed [63:0] p;
    logic signed [63:0] q;
    p = a * b;
    p = p + (64'sd1 <<< (FB - 1));
    q = p >>> FB;
    if (q > 64'(WMAX)) begin
      return WMAX;
    end
    if (q < 64'(WMIN)) begin
      return WMIN;
    end
    return word_t'(q[DW-1:0]);
  endfunction

  function automatic word_t half(input word_t x);
    logic signed [DW:0] s;
    s = x;
    s = s + (x[DW-1] ? 1 : 0);
    return word_t'(s[DW:1]);
  endfunction

endpackage

### hw/rtl/lbm_div.sv
module lbm_div (
  input  logic          clk,
  input  lbm_pkg::word_t num,
  input  lbm_pkg::word_t den,
  output lbm_pkg::word_t quot
);

  logic [lbm_pkg::DW-1:0] mag;
  logic [lbm_pkg::NB-1:0] nfull;
  lbm_pkg::div_flag_t     fl0;

  logic [lbm_pkg::QB-1:0] rem  [0:lbm_pkg::QB];
  logic [lbm_pkg::QB-1:0] low  [0:lbm_pkg::QB];
  logic [lbm_pkg::QB-1:0] qv   [0:lbm_pkg::QB];
  logic [lbm_pkg::QB-1:0] dv   [0:lbm_pkg::QB];
  lbm_pkg::div_flag_t     fl   [0:lbm_pkg::QB];

  logic [lbm_pkg::QB:0]   r2   [1:lbm_pkg::QB];
  logic                   ge   [1:lbm_pkg::QB];

  lbm_pkg::word_t         quot_next;
  lbm_pkg::word_t         qpos;

  always_comb begin
    mag     = num[lbm_pkg::DW-1] ? lbm_pkg::DW'(-num) : lbm_pkg::DW'(num);
    nfull   = {mag, {lbm_pkg::FB{1'b0}}};
    fl0.neg = num[lbm_pkg::DW-1];
    fl0.pos = !num[lbm_pkg::DW-1] && (num != '0);
    fl0.bad = den[lbm_pkg::DW-1] || (den == '0);
    fl0.ovf = lbm_pkg::QB'(nfull[lbm_pkg::NB-1:lbm_pkg::QB]) >= den[lbm_pkg::QB-1:0];
  end

  always_comb begin
    for (int k = 1; k <= lbm_pkg::QB; k++) begin
      r2[k] = {rem[k-1], low[k-1][lbm_pkg::QB-1]};
      ge[k] = r2[k] >= {1'b0, dv[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= lbm_pkg::QB'(nfull[lbm_pkg::NB-1:lbm_pkg::QB]);
    low[0] <= nfull[lbm_pkg::QB-1:0];
    qv[0]  <= '0;
    dv[0]  <= den[lbm_pkg::QB-1:0];
    fl[0]  <= fl0;
    for (int k = 1; k <= lbm_pkg::QB; k++) begin
      rem[k] <= ge[k] ? lbm_pkg::QB'(r2[k] - {1'b0, dv[k-1]}) : r2[k][lbm_pkg::QB-1:0];
      low[k] <= {low[k-1][lbm_pkg::QB-2:0], 1'b0};
      qv[k]  <= {qv[k-1][lbm_pkg::QB-2:0], ge[k]};
      dv[k]  <= dv[k-1];
      fl[k]  <= fl[k-1];
    end
  end

  always_comb begin
    qpos = lbm_pkg::word_t'({1'b0, qv[lbm_pkg::QB]});
    if (fl[lbm_pkg::QB].bad) begin
      if (fl[lbm_pkg::QB].pos) begin
        quot_next = lbm_pkg::WMAX;
      end else if (fl[lbm_pkg::QB].neg) begin
        quot_next = lbm_pkg::WMIN;
      end else begin
        quot_next = '0;
      end
    end else if (fl[lbm_pkg::QB].ovf) begin
      quot_next = fl[lbm_pkg::QB].neg ? lbm_pkg::WMIN : lbm_pkg::WMAX;
    end else begin
      quot_next = fl[lbm_pkg::QB].neg ? -qpos : qpos;
    end
  end

  always_ff @(posedge clk) begin
    quot <= quot_next;
  end

endmodule

### hw/rtl/lattice_boltzmann_d2q9_cell_update_core.sv
// D2Q9 BGK collision core with bounce-back, Zou-He inlet and Zou-He outlet cells.
// Path: input register, sum stage, divider-operand stage, divider pipeline, post-divide stages
//   and output register; done is registered with the outputs and holds for one cycle.
// Throughput: one cell per cycle; busy stays low, the two dividers are fully
//   pipelined at one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module lattice_boltzmann_d2q9_cell_update_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  lbm_pkg::word_t pop_rest,
  input  lbm_pkg::word_t pop_east,
  input  lbm_pkg::word_t pop_north,
  input  lbm_pkg::word_t pop_west,
  input  lbm_pkg::word_t pop_south,
  input  lbm_pkg::word_t pop_northeast,
  input  lbm_pkg::word_t pop_northwest,
  input  lbm_pkg::word_t pop_southwest,
  input  lbm_pkg::word_t pop_southeast,
  input  logic [1:0]     kind,
  input  logic [27:0]    inlet_speed,
  output lbm_pkg::word_t out_rest,
  output lbm_pkg::word_t out_east,
  output lbm_pkg::word_t out_north,
  output lbm_pkg::word_t out_west,
  output lbm_pkg::word_t out_south,
  output lbm_pkg::word_t out_northeast,
  output lbm_pkg::word_t out_northwest,
  output lbm_pkg::word_t out_southwest,
  output lbm_pkg::word_t out_southeast,
  output lbm_pkg::word_t density,
  output lbm_pkg::word_t velocity_x,
  output lbm_pkg::word_t velocity_y
);

  localparam int LAT = 3 + lbm_pkg::DIV_LAT + lbm_pkg::QN + 1;

  logic [29:0] relax_rate;
  logic [30:0] outlet_density;

  lbm_pkg::in_t  c1;
  lbm_pkg::aux_t a2;
  lbm_pkg::in_t  c2;
  lbm_pkg::ctx_t c3;
  lbm_pkg::ctx_t c3_next;
  lbm_pkg::aux_t a2_next;
  lbm_pkg::word_t num_a, den_a, num_b;
  lbm_pkg::word_t num_a_next, den_a_next, num_b_next;
  logic v1, v2, v3;

  lbm_pkg::ctx_t line [0:lbm_pkg::DIV_LAT-1];
  logic [lbm_pkg::DIV_LAT-1:0] lv;
  lbm_pkg::word_t qa, qb;

  lbm_pkg::post_t pst [0:lbm_pkg::QN-1];
  lbm_pkg::post_t nx  [0:lbm_pkg::QN-1];
  logic [lbm_pkg::QN-1:0] pv;

  lbm_pkg::word_t [lbm_pkg::NDIR-1:0] g_next;
  lbm_pkg::word_t [lbm_pkg::NDIR-1:0] g;
  lbm_pkg::word_t dens_out, vx_out, vy_out;

  lbm_pkg::word_t e;
  lbm_pkg::word_t bsel;
  lbm_pkg::word_t rho_full;
  lbm_pkg::word_t om;
  logic [lbm_pkg::DW-1:0] mag2, mag1;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign om     = lbm_pkg::word_t'({2'b00, relax_rate});

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate     <= 30'd474267590;
      outlet_density <= 31'd268435456;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        lbm_pkg::REG_RELAX:  relax_rate     <= pwdata[29:0];
        lbm_pkg::REG_OUTDEN: outlet_density <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lbm_pkg::REG_RELAX:  prdata = {2'b00, relax_rate};
      lbm_pkg::REG_OUTDEN: prdata = {1'b0, outlet_density};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      lv <= '0;
      pv <= '0;
      done <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      lv <= {lv[lbm_pkg::DIV_LAT-2:0], v3};
      pv <= {pv[lbm_pkg::QN-2:0], lv[lbm_pkg::DIV_LAT-1]};
      done <= pv[lbm_pkg::QN-1];
    end
  end

  always_ff @(posedge clk) begin
    c1.f     <= {pop_southeast, pop_southwest, pop_northwest, pop_northeast,
                 pop_south, pop_west, pop_north, pop_east, pop_rest};
    c1.kind  <= lbm_pkg::kind_t'(kind);
    c1.speed <= inlet_speed;
  end

  always_comb begin
    a2_next.r5  = lbm_pkg::addq(lbm_pkg::addq(lbm_pkg::addq(lbm_pkg::addq(
                    c1.f[0], c1.f[1]), c1.f[2]), c1.f[3]), c1.f[4]);
    a2_next.mxp = lbm_pkg::addq(lbm_pkg::addq(c1.f[1], c1.f[5]), c1.f[8]);
    a2_next.mxn = lbm_pkg::addq(lbm_pkg::addq(c1.f[3], c1.f[6]), c1.f[7]);
    a2_next.myp = lbm_pkg::addq(lbm_pkg::addq(c1.f[2], c1.f[5]), c1.f[6]);
    a2_next.myn = lbm_pkg::addq(lbm_pkg::addq(c1.f[4], c1.f[7]), c1.f[8]);
    a2_next.s   = lbm_pkg::addq(lbm_pkg::addq(c1.f[0], c1.f[2]), c1.f[4]);
    a2_next.h   = lbm_pkg::half(lbm_pkg::subq(c1.f[4], c1.f[2]));
  end

  always_ff @(posedge clk) begin
    c2 <= c1;
    a2 <= a2_next;
  end

  always_comb begin
    rho_full = lbm_pkg::addq(lbm_pkg::addq(lbm_pkg::addq(lbm_pkg::addq(
                 a2.r5, c2.f[5]), c2.f[6]), c2.f[7]), c2.f[8]);
    bsel = (c2.kind == lbm_pkg::KIND_INLET) ? a2.mxn : a2.mxp;
    c3_next.f     = c2.f;
    c3_next.kind  = c2.kind;
    c3_next.speed = c2.speed;
    c3_next.h     = a2.h;
    c3_next.rho   = rho_full;
    num_b_next    = lbm_pkg::subq(a2.myp, a2.myn);
    case (c2.kind)
      lbm_pkg::KIND_INLET: begin
        num_a_next = lbm_pkg::addq(a2.s, lbm_pkg::addq(bsel, bsel));
        den_a_next = lbm_pkg::subq(lbm_pkg::ONE, lbm_pkg::word_t'({4'b0, c2.speed}));
      end
      lbm_pkg::KIND_OUTLET: begin
        num_a_next = lbm_pkg::addq(a2.s, lbm_pkg::addq(bsel, bsel));
        den_a_next = lbm_pkg::word_t'({1'b0, outlet_density});
      end
      default: begin
        num_a_next = lbm_pkg::subq(a2.mxp, a2.mxn);
        den_a_next = rho_full;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    c3    <= c3_next;
    num_a <= num_a_next;
    den_a <= den_a_next;
    num_b <= num_b_next;
  end

  lbm_div u_div_a (
    .clk  (clk),
    .num  (num_a),
    .den  (den_a),
    .quot (qa)
  );

  lbm_div u_div_b (
    .clk  (clk),
    .num  (num_b),
    .den  (c3.rho),
    .quot (qb)
  );

  always_ff @(posedge clk) begin
    line[0] <= c3;
    for (int k = 1; k < lbm_pkg::DIV_LAT; k++) begin
      line[k] <= line[k-1];
    end
  end

  always_comb begin
    nx[0]      = '0;
    nx[0].f    = line[lbm_pkg::DIV_LAT-1].f;
    nx[0].kind = line[lbm_pkg::DIV_LAT-1].kind;
    nx[0].h    = line[lbm_pkg::DIV_LAT-1].h;
    case (line[lbm_pkg::DIV_LAT-1].kind)
      lbm_pkg::KIND_INLET: begin
        nx[0].rho = qa;
        nx[0].u   = lbm_pkg::word_t'({4'b0, line[lbm_pkg::DIV_LAT-1].speed});
        nx[0].vy  = '0;
      end
      lbm_pkg::KIND_OUTLET: begin
        nx[0].rho = lbm_pkg::word_t'({1'b0, outlet_density});
        nx[0].u   = lbm_pkg::subq(qa, lbm_pkg::ONE);
        nx[0].vy  = '0;
      end
      default: begin
        nx[0].rho = line[lbm_pkg::DIV_LAT-1].rho;
        nx[0].u   = qa;
        nx[0].vy  = qb;
      end
    endcase

    nx[1]       = pst[0];
    nx[1].ru    = lbm_pkg::mulq(pst[0].rho, pst[0].u);
    nx[1].uu    = lbm_pkg::mulq(pst[0].u, pst[0].u);
    nx[1].vv    = lbm_pkg::mulq(pst[0].vy, pst[0].vy);
    nx[1].rw[0] = lbm_pkg::mulq(pst[0].rho, lbm_pkg::W_REST);
    nx[1].rw[1] = lbm_pkg::mulq(pst[0].rho, lbm_pkg::W_AXIS);
    nx[1].rw[2] = lbm_pkg::mulq(pst[0].rho, lbm_pkg::W_DIAG);

    nx[2]         = pst[1];
    e             = lbm_pkg::addq(pst[1].ru, pst[1].ru);
    mag2          = e[lbm_pkg::DW-1] ? lbm_pkg::DW'(-e) : lbm_pkg::DW'(e);
    mag1          = pst[1].ru[lbm_pkg::DW-1] ? lbm_pkg::DW'(-pst[1].ru)
                                             : lbm_pkg::DW'(pst[1].ru);
    nx[2].ru2_neg = e[lbm_pkg::DW-1];
    nx[2].ru_neg  = pst[1].ru[lbm_pkg::DW-1];
    nx[2].p3      = 64'(mag2) * 64'(lbm_pkg::DIV3_MAGIC);
    nx[2].p6      = 64'(mag1) * 64'(lbm_pkg::DIV3_MAGIC);
    nx[2].qs      = lbm_pkg::addq(pst[1].uu, pst[1].vv);

    nx[3]     = pst[2];
    nx[3].tq  = pst[2].ru2_neg ? -lbm_pkg::word_t'(pst[2].p3 >> lbm_pkg::DIV3_SHIFT)
                               :  lbm_pkg::word_t'(pst[2].p3 >> lbm_pkg::DIV3_SHIFT);
    nx[3].r6  = pst[2].ru_neg  ? -lbm_pkg::word_t'(pst[2].p6 >> lbm_pkg::DIV6_SHIFT)
                               :  lbm_pkg::word_t'(pst[2].p6 >> lbm_pkg::DIV6_SHIFT);
    nx[3].usq = lbm_pkg::half(lbm_pkg::addq(lbm_pkg::addq(pst[2].qs, pst[2].qs),
                                            pst[2].qs));

    nx[4] = pst[3];
    case (pst[3].kind)
      lbm_pkg::KIND_INLET: begin
        nx[4].f[1] = lbm_pkg::addq(pst[3].f[3], pst[3].tq);
        nx[4].f[5] = lbm_pkg::addq(lbm_pkg::addq(pst[3].f[7], pst[3].h), pst[3].r6);
        nx[4].f[8] = lbm_pkg::addq(lbm_pkg::subq(pst[3].f[6], pst[3].h), pst[3].r6);
      end
      lbm_pkg::KIND_OUTLET: begin
        nx[4].f[3] = lbm_pkg::subq(pst[3].f[1], pst[3].tq);
        nx[4].f[7] = lbm_pkg::subq(lbm_pkg::subq(pst[3].f[5], pst[3].h), pst[3].r6);
        nx[4].f[6] = lbm_pkg::subq(lbm_pkg::addq(pst[3].f[8], pst[3].h), pst[3].r6);
      end
      default: ;
    endcase
    for (int m = 0; m < lbm_pkg::NDIR; m++) begin
      e = '0;
      if (lbm_pkg::DIR_X[m] > 0) e = lbm_pkg::addq(e, pst[3].u);
      if (lbm_pkg::DIR_X[m] < 0) e = lbm_pkg::subq(e, pst[3].u);
      if (lbm_pkg::DIR_Y[m] > 0) e = lbm_pkg::addq(e, pst[3].vy);
      if (lbm_pkg::DIR_Y[m] < 0) e = lbm_pkg::subq(e, pst[3].vy);
      nx[4].t[m] = lbm_pkg::addq(lbm_pkg::addq(e, e), e);
    end

    nx[5] = pst[4];
    nx[6] = pst[5];
    nx[7] = pst[6];
    nx[8] = pst[7];
    nx[9] = pst[8];
    for (int m = 0; m < lbm_pkg::NDIR; m++) begin
      nx[5].tt[m]   = lbm_pkg::mulq(pst[4].t[m], pst[4].t[m]);
      nx[6].poly[m] = lbm_pkg::subq(lbm_pkg::addq(lbm_pkg::addq(lbm_pkg::ONE, pst[5].t[m]),
                                                  lbm_pkg::half(pst[5].tt[m])), pst[5].usq);
      nx[7].feq[m]  = lbm_pkg::mulq(pst[6].rw[lbm_pkg::W_SEL[m]], pst[6].poly[m]);
      nx[8].diff[m] = lbm_pkg::subq(pst[7].f[m], pst[7].feq[m]);
      nx[9].prod[m] = lbm_pkg::mulq(om, pst[8].diff[m]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < lbm_pkg::QN; k++) begin
      pst[k] <= nx[k];
    end
  end

  always_comb begin
    for (int m = 0; m < lbm_pkg::NDIR; m++) begin
      if (pst[lbm_pkg::QN-1].kind == lbm_pkg::KIND_SOLID) begin
        g_next[m] = pst[lbm_pkg::QN-1].f[lbm_pkg::REVERSE[m]];
      end else begin
        g_next[m] = lbm_pkg::subq(pst[lbm_pkg::QN-1].f[m], pst[lbm_pkg::QN-1].prod[m]);
      end
    end
  end

  always_ff @(posedge clk) begin
    g        <= g_next;
    dens_out <= pst[lbm_pkg::QN-1].rho;
    vx_out   <= pst[lbm_pkg::QN-1].u;
    vy_out   <= pst[lbm_pkg::QN-1].vy;
  end

  assign out_rest      = g[0];
  assign out_east      = g[1];
  assign out_north     = g[2];
  assign out_west      = g[3];
  assign out_south     = g[4];
  assign out_northeast = g[5];
  assign out_northwest = g[6];
  assign out_southwest = g[7];
  assign out_southeast = g[8];
  assign density       = dens_out;
  assign velocity_x    = vx_out;
  assign velocity_y    = vy_out;

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transfer did not complete at fixed latency");

  a_no_relax : assert property (@(posedge clk) disable iff (rst)
    (pv[8] && relax_rate == '0 && pst[8].kind != lbm_pkg::KIND_SOLID)
      |-> ##2 (out_east == $past(pst[8].f[1], 2)))
    else $error("zero relaxation changed a population");

  a_boundary_vy : assert property (@(posedge clk) disable iff (rst)
    (pv[lbm_pkg::QN-1] && (pst[lbm_pkg::QN-1].kind == lbm_pkg::KIND_INLET ||
                           pst[lbm_pkg::QN-1].kind == lbm_pkg::KIND_OUTLET))
      |=> (done && velocity_y == '0))
    else $error("boundary cell with nonzero y velocity");

endmodule
